### rtl/tsspi_pkg.sv
package tsspi_pkg;

    localparam int unsigned TAIL_W  = 4;
    localparam int unsigned BCNT_W  = 5;
    localparam int unsigned PHASE_W = 3;

    // Command codes carried in func.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_FIFO  = 2'd3;

    // Serial sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TX_LOW  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_TX_HIGH = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RX_LOW  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RX_HIGH = 3'd4;
    localparam logic [PHASE_W-1:0] PH_TAIL    = 3'd5;

    localparam logic [7:0]        READ_CMD_BIT  = 8'h80;
    localparam logic [BCNT_W-1:0] WRITE_BITS    = 5'd16;
    localparam logic [BCNT_W-1:0] BYTE_BITS     = 5'd8;
    localparam logic [TAIL_W-1:0] TAIL_RESET    = 4'd7;

    // Configuration register indexes.
    localparam logic CFG_IDX_TAIL_DELAY = 1'b0;

    typedef struct packed {
        logic sck;
        logic sdio_out;
        logic sdio_drive;
        logic reg_select_n;
        logic fifo_select_n;
    } pins_t;

    localparam pins_t PINS_IDLE = '{sck: 1'b0, sdio_out: 1'b1, sdio_drive: 1'b1,
                                    reg_select_n: 1'b1, fifo_select_n: 1'b1};

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [1:0]         op_kind;
        logic [BCNT_W-1:0]  bit_count;
        logic [15:0]        tx_shift;
        logic [7:0]         rx_shift;
        logic [TAIL_W-1:0]  delay_count;
        logic [7:0]         last_read;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] write_word;
        logic [6:0]  reg_address;
        logic        sdo_bit;
    } item_t;

    typedef struct packed {
        pins_t       pins;
        logic [7:0]  read_data;
        logic        done_res;
        logic        busy_res;
        logic        rejected;
    } result_t;

endpackage

### rtl/tsspi_step.sv
module tsspi_step
    import tsspi_pkg::*;
(
    input  seq_state_t        state,
    input  item_t             item,
    input  logic [TAIL_W-1:0] tail_delay,
    output seq_state_t        state_next,
    output result_t           result
);

    logic              idle;
    logic              rs;
    logic              fs;
    logic [BCNT_W-1:0] tx_bits;
    logic [BCNT_W-1:0] bc_inc;
    seq_state_t        st;

    // Phase codes above the tail phase behave as idle.
    assign idle = (state.phase == PH_IDLE) || (state.phase > PH_TAIL);

    always_comb
    begin
        st = state;
        if (idle)
        begin
            st.phase = PH_IDLE;
        end
        result.rejected = 1'b0;
        if (idle && (item.func != FUNC_TICK))
        begin
            st.op_kind     = item.func;
            st.bit_count   = '0;
            st.rx_shift    = '0;
            st.delay_count = '0;
            unique case (item.func)
                FUNC_WRITE:
                begin
                    st.tx_shift = item.write_word;
                    st.phase    = PH_TX_LOW;
                end
                FUNC_READ:
                begin
                    st.tx_shift = {READ_CMD_BIT | {1'b0, item.reg_address}, 8'h00};
                    st.phase    = PH_TX_LOW;
                end
                default:
                begin
                    st.tx_shift = '0;
                    st.phase    = PH_RX_LOW;
                end
            endcase
        end
        else if (!idle && (item.func != FUNC_TICK))
        begin
            result.rejected = 1'b1;
        end

        rs      = !((st.op_kind == FUNC_WRITE) || (st.op_kind == FUNC_READ));
        fs      = !(st.op_kind == FUNC_FIFO);
        tx_bits = (st.op_kind == FUNC_WRITE) ? WRITE_BITS : BYTE_BITS;
        bc_inc  = st.bit_count + 1'b1;

        state_next       = st;
        result.pins      = PINS_IDLE;
        result.done_res  = 1'b0;
        result.busy_res  = 1'b1;

        unique case (st.phase)
            PH_TX_LOW:
            begin
                result.pins = '{sck: 1'b0, sdio_out: st.tx_shift[15], sdio_drive: 1'b1,
                                reg_select_n: rs, fifo_select_n: fs};
                state_next.phase = PH_TX_HIGH;
            end
            PH_TX_HIGH:
            begin
                result.pins = '{sck: 1'b1, sdio_out: st.tx_shift[15], sdio_drive: 1'b1,
                                reg_select_n: rs, fifo_select_n: fs};
                state_next.tx_shift = {st.tx_shift[14:0], 1'b0};
                if (bc_inc >= tx_bits)
                begin
                    state_next.bit_count = '0;
                    if (st.op_kind == FUNC_WRITE)
                    begin
                        state_next.phase       = PH_TAIL;
                        state_next.delay_count = '0;
                    end
                    else
                    begin
                        state_next.phase = PH_RX_LOW;
                    end
                end
                else
                begin
                    state_next.bit_count = bc_inc;
                    state_next.phase     = PH_TX_LOW;
                end
            end
            PH_RX_LOW:
            begin
                result.pins = '{sck: 1'b0, sdio_out: 1'b1, sdio_drive: 1'b0,
                                reg_select_n: rs, fifo_select_n: fs};
                state_next.phase = PH_RX_HIGH;
            end
            PH_RX_HIGH:
            begin
                result.pins = '{sck: 1'b1, sdio_out: 1'b1, sdio_drive: 1'b0,
                                reg_select_n: rs, fifo_select_n: fs};
                state_next.rx_shift = {st.rx_shift[6:0], item.sdo_bit};
                if (bc_inc >= BYTE_BITS)
                begin
                    state_next.bit_count   = '0;
                    state_next.phase       = PH_TAIL;
                    state_next.delay_count = '0;
                end
                else
                begin
                    state_next.bit_count = bc_inc;
                    state_next.phase     = PH_RX_LOW;
                end
            end
            PH_TAIL:
            begin
                if (st.delay_count >= tail_delay)
                begin
                    if ((st.op_kind == FUNC_READ) || (st.op_kind == FUNC_FIFO))
                    begin
                        state_next.last_read = st.rx_shift;
                    end
                    result.done_res        = 1'b1;
                    result.busy_res        = 1'b0;
                    state_next.phase       = PH_IDLE;
                    state_next.delay_count = '0;
                end
                else
                begin
                    result.pins = '{sck: 1'b0, sdio_out: 1'b1,
                                    sdio_drive: (st.op_kind != FUNC_FIFO),
                                    reg_select_n: rs, fifo_select_n: fs};
                    state_next.delay_count = st.delay_count + 1'b1;
                end
            end
            default:
            begin
                result.busy_res = 1'b0;
            end
        endcase

        result.read_data = state_next.last_read;
    end

endmodule

### rtl/three_wire_spi_master_radio_core.sv
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle while results are taken; the input register
// and the result register let a new item enter while a finished result still
// waits to be taken. Each item yields exactly one result, computed in one pass.
// Reset (rst_n low, asynchronous) empties both registers, returns the sequencer
// to idle and sets tail_delay to 7; the pin outputs are not reset.
module three_wire_spi_master_radio_core
    import tsspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  func,
    input  logic [15:0] write_word,
    input  logic [6:0]  reg_address,
    input  logic        sdo_bit,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        sck,
    output logic        sdio_out,
    output logic        sdio_drive,
    output logic        reg_select_n,
    output logic        fifo_select_n,
    output logic [7:0]  read_data,
    output logic        done_res,
    output logic        busy_res,
    output logic        rejected
);

    logic [TAIL_W-1:0] tail_delay_reg;
    logic              item_valid_reg;
    item_t             item_reg;
    logic              result_valid_reg;
    result_t           result_reg;
    seq_state_t        state_reg;
    seq_state_t        state_next;
    result_t           result_next;
    logic              out_free;
    logic              advance;
    logic              cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == CFG_IDX_TAIL_DELAY);
    assign prdata  = cfg_hit ? {{(32 - TAIL_W){1'b0}}, tail_delay_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_delay_reg <= TAIL_RESET;
        end
        else if (psel && penable && pwrite && cfg_hit)
        begin
            tail_delay_reg <= pwdata[TAIL_W-1:0];
        end
    end

    assign out_free   = !result_valid_reg || result_ready;
    assign advance    = item_valid_reg && out_free;
    assign item_ready = !item_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= '{func: func, write_word: write_word,
                          reg_address: reg_address, sdo_bit: sdo_bit};
        end
    end

    tsspi_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .tail_delay (tail_delay_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                result_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign sck           = result_reg.pins.sck;
    assign sdio_out      = result_reg.pins.sdio_out;
    assign sdio_drive    = result_reg.pins.sdio_drive;
    assign reg_select_n  = result_reg.pins.reg_select_n;
    assign fifo_select_n = result_reg.pins.fifo_select_n;
    assign read_data     = result_reg.read_data;
    assign done_res      = result_reg.done_res;
    assign busy_res      = result_reg.busy_res;
    assign rejected      = result_reg.rejected;

endmodule

### rtl/tsspi_checker.sv
module tsspi_checker
    import tsspi_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        item_valid,
    input logic        item_ready,
    input logic [1:0]  func,
    input logic [15:0] write_word,
    input logic [6:0]  reg_address,
    input logic        sdo_bit,
    input logic        result_valid,
    input logic        result_ready,
    input logic        sck,
    input logic        sdio_out,
    input logic        sdio_drive,
    input logic        reg_select_n,
    input logic        fifo_select_n,
    input logic [7:0]  read_data,
    input logic        done_res,
    input logic        busy_res,
    input logic        rejected
);

    // A transaction finishing on this transfer is no longer busy.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> !busy_res)
        else $error("done and busy reported together");

    // Whenever an offered result is not busy, both selects are released, the clock is low and sdio is driven.
    a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !busy_res |-> reg_select_n && fifo_select_n && !sck && sdio_drive)
        else $error("pins not at idle levels outside a transaction");

    // Never both selects active at once.
    a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> reg_select_n || fifo_select_n)
        else $error("both chip selects active");

    // A waiting result is held until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(read_data)
            && $stable(done_res) && $stable(busy_res))
        else $error("pending result changed before transfer");

endmodule

bind three_wire_spi_master_radio_core tsspi_checker u_tsspi_checker (.*);
